// ===== rtl/differential_drive_odometry_top_defines.svh =====
// assertion macros shared by the odometry rtl
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH

// checked on every clock edge outside of reset
`define DDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define DDO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/ddo_pkg.sv =====
// types, constants and helper functions for the odometry block
package ddo_pkg;

    localparam int unsigned CORDIC_STEPS_DEF = 24;

    // register indexes of the configuration port
    localparam logic CFG_DIST_PER_COUNT = 1'b0;
    localparam logic CFG_INV_WHEEL_BASE = 1'b1;

    localparam logic [31:0] DIST_PER_COUNT_RST = 32'd259542;
    localparam logic [31:0] INV_WHEEL_BASE_RST = 32'd1118481;

    // angles in q3.29, cordic gain in q2.30
    localparam logic signed [34:0] PI_Q29      = 35'sd1686629713;
    localparam logic signed [34:0] TWO_PI_Q29  = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q29 = 35'sd843314857;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] count_left;
        logic signed [31:0] count_right;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
    } t_out;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -68'sh0_0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // truncated arctangent of 2^-i in q2.30
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        unique case (i)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            5'd24: r = 34'sd63;
            5'd25: r = 34'sd31;
            5'd26: r = 34'sd15;
            5'd27: r = 34'sd8;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            5'd30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/differential_drive_odometry_top.sv =====
// differential drive dead-reckoning odometry, sequenced over one shared multiplier
//
// input channel (i_valid / o_ready, payload i_data): one transaction carries the
// absolute left and right encoder counts. output channel (o_valid / i_ready,
// payload o_data): one transaction per input with x, y (q16.16 cm) and heading
// (q3.29 rad) after the update.
// config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 distance per count, 1 inverse wheel base), no wait states.
// one item is in flight at a time: o_ready is high only while idle, so the next
// input is accepted only after the last one has been handed to the output register.
// the sequence runs the cordic loop, one rotation a cycle, plus the five passes
// through the shared 34x34 multiplier and the folding steps around them.
// the output register holds a finished result until it is taken; while it is
// full the next item may already be accepted and worked on, and that item waits
// in its last step until the receiver takes the older result.
// reset (synchronous, active low): encoder history, position and heading go to
// zero, config registers to their defaults, no result pending.
module differential_drive_odometry_top #(
    parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ddo_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ddo_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);
    import ddo_pkg::*;

    `include "differential_drive_odometry_top_defines.svh"

    // cordic iteration counter
    localparam int unsigned IW = $clog2(CORDIC_STEPS);
    localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_STEPS - 1);

    // sequencer codes
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ML   = 4'd1;   // left delta times distance per count
    localparam logic [3:0] ST_MR   = 4'd2;   // right delta times distance per count
    localparam logic [3:0] ST_DR   = 4'd3;   // take right wheel distance
    localparam logic [3:0] ST_DF   = 4'd4;   // center and wheel difference
    localparam logic [3:0] ST_MT   = 4'd5;   // difference times inverse wheel base
    localparam logic [3:0] ST_TH   = 4'd6;   // take heading change
    localparam logic [3:0] ST_MID  = 4'd7;   // midpoint and new heading, 2pi fold
    localparam logic [3:0] ST_HALF = 4'd8;   // fold midpoint into +-pi/2
    localparam logic [3:0] ST_COR  = 4'd9;   // cordic rotations
    localparam logic [3:0] ST_NEG  = 4'd10;  // undo the pi shift
    localparam logic [3:0] ST_MX   = 4'd11;  // center times cosine
    localparam logic [3:0] ST_MY   = 4'd12;  // center times sine, x update
    localparam logic [3:0] ST_FIN  = 4'd13;  // y update
    localparam logic [3:0] ST_OUT  = 4'd14;  // hand over to the output register

    logic [3:0]          r_state;
    logic [IW-1:0]       r_iter;

    // configuration
    logic [31:0]         r_dpc;
    logic [31:0]         r_iwb;

    // architectural state
    logic signed [31:0]  r_last_left;
    logic signed [31:0]  r_last_right;
    logic signed [31:0]  r_xacc;
    logic signed [31:0]  r_yacc;
    logic signed [31:0]  r_angle;

    // working registers
    logic signed [31:0]  r_dlc;
    logic signed [31:0]  r_drc;
    logic signed [67:0]  r_prod;
    logic signed [31:0]  r_dl;
    logic signed [31:0]  r_dr;
    logic signed [31:0]  r_center;
    logic signed [31:0]  r_diff;
    logic signed [31:0]  r_dtheta;
    logic signed [34:0]  r_mid;
    logic signed [31:0]  r_head;
    logic                r_neg;
    logic signed [33:0]  r_z;
    logic signed [33:0]  r_cx;
    logic signed [33:0]  r_cy;
    logic signed [31:0]  r_nx;
    logic signed [31:0]  r_ny;

    // output register
    logic                r_out_valid;
    t_out                r_out;

    // shared multiplier
    logic signed [33:0]  w_mul_a;
    logic signed [33:0]  w_mul_b;
    logic signed [67:0]  w_prod;

    // datapath helpers
    logic signed [32:0]  w_sum;
    logic signed [32:0]  w_dif;
    logic signed [34:0]  w_mid_raw;
    logic signed [34:0]  w_mid_fold;
    logic signed [34:0]  w_nh_raw;
    logic signed [34:0]  w_nh_fold;
    logic signed [34:0]  w_half;
    logic                w_half_neg;
    logic signed [33:0]  w_xs;
    logic signed [33:0]  w_ys;
    logic signed [33:0]  w_atan;
    logic                w_out_free;

    assign o_ready    = (r_state == ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign w_out_free = !r_out_valid || i_ready;

    // operand select for the one multiplier
    always_comb begin
        unique case (r_state)
            ST_ML: begin
                w_mul_a = 34'(r_dlc);
                w_mul_b = $signed({2'b00, r_dpc});
            end
            ST_MR: begin
                w_mul_a = 34'(r_drc);
                w_mul_b = $signed({2'b00, r_dpc});
            end
            ST_MT: begin
                w_mul_a = 34'(r_diff);
                w_mul_b = $signed({2'b00, r_iwb});
            end
            ST_MX: begin
                w_mul_a = 34'(r_center);
                w_mul_b = r_cx;
            end
            ST_MY: begin
                w_mul_a = 34'(r_center);
                w_mul_b = r_cy;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // center and wheel difference
    assign w_sum = 33'(r_dl) + 33'(r_dr);
    assign w_dif = 33'(r_dl) - 33'(r_dr);

    // midpoint heading and new heading, each with one 2pi fold
    assign w_mid_raw = 35'(r_angle) + 35'(r_dtheta >>> 1);
    assign w_nh_raw  = 35'(r_angle) + 35'(r_dtheta);

    always_comb begin
        priority if (w_mid_raw > PI_Q29) begin
            w_mid_fold = w_mid_raw - TWO_PI_Q29;
        end else if (w_mid_raw < -PI_Q29) begin
            w_mid_fold = w_mid_raw + TWO_PI_Q29;
        end else begin
            w_mid_fold = w_mid_raw;
        end
        priority if (w_nh_raw > PI_Q29) begin
            w_nh_fold = w_nh_raw - TWO_PI_Q29;
        end else if (w_nh_raw < -PI_Q29) begin
            w_nh_fold = w_nh_raw + TWO_PI_Q29;
        end else begin
            w_nh_fold = w_nh_raw;
        end
    end

    // outside +-pi/2 rotate by pi and flip the signs afterwards
    always_comb begin
        priority if (r_mid > HALF_PI_Q29) begin
            w_half     = r_mid - PI_Q29;
            w_half_neg = 1'b1;
        end else if (r_mid < -HALF_PI_Q29) begin
            w_half     = r_mid + PI_Q29;
            w_half_neg = 1'b1;
        end else begin
            w_half     = r_mid;
            w_half_neg = 1'b0;
        end
    end

    // cordic shifter and angle table
    assign w_xs   = r_cx >>> r_iter;
    assign w_ys   = r_cy >>> r_iter;
    assign w_atan = atan_q30(5'(r_iter));

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_iter       <= '0;
            r_dpc        <= DIST_PER_COUNT_RST;
            r_iwb        <= INV_WHEEL_BASE_RST;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_xacc       <= '0;
            r_yacc       <= '0;
            r_angle      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DIST_PER_COUNT: r_dpc <= i_cfg_data;
                    CFG_INV_WHEEL_BASE: r_iwb <= i_cfg_data;
                    default: ;
                endcase
            end

            // the hand-over step drives valid itself
            if (r_out_valid && i_ready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        // wrapping deltas against the previous counts
                        r_dlc        <= i_data.count_left - r_last_left;
                        r_drc        <= i_data.count_right - r_last_right;
                        r_last_left  <= i_data.count_left;
                        r_last_right <= i_data.count_right;
                        r_state      <= ST_ML;
                    end
                end
                ST_ML: begin
                    r_prod  <= w_prod;
                    r_state <= ST_MR;
                end
                ST_MR: begin
                    r_dl    <= sat32(r_prod >>> 8);
                    r_prod  <= w_prod;
                    r_state <= ST_DR;
                end
                ST_DR: begin
                    r_dr    <= sat32(r_prod >>> 8);
                    r_state <= ST_DF;
                end
                ST_DF: begin
                    r_center <= w_sum[32:1];
                    r_diff   <= sat32(68'(w_dif));
                    r_state  <= ST_MT;
                end
                ST_MT: begin
                    r_prod  <= w_prod;
                    r_state <= ST_TH;
                end
                ST_TH: begin
                    r_dtheta <= sat32(r_prod >>> 11);
                    r_state  <= ST_MID;
                end
                ST_MID: begin
                    r_mid   <= w_mid_fold;
                    r_head  <= sat32(68'(w_nh_fold));
                    r_state <= ST_HALF;
                end
                ST_HALF: begin
                    r_z     <= 34'(w_half <<< 1);
                    r_neg   <= w_half_neg;
                    r_cx    <= CORDIC_GAIN;
                    r_cy    <= '0;
                    r_iter  <= '0;
                    r_state <= ST_COR;
                end
                ST_COR: begin
                    if (r_z >= 0) begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_z  <= r_z - w_atan;
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_z  <= r_z + w_atan;
                    end
                    if (r_iter == ITER_LAST) begin
                        r_state <= ST_NEG;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                ST_NEG: begin
                    if (r_neg) begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                    end
                    r_state <= ST_MX;
                end
                ST_MX: begin
                    r_prod  <= w_prod;
                    r_state <= ST_MY;
                end
                ST_MY: begin
                    r_nx    <= sat32(68'(r_xacc) + (r_prod >>> 30));
                    r_prod  <= w_prod;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_ny    <= sat32(68'(r_yacc) + (r_prod >>> 30));
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // wait here while an older result is still unread
                    if (w_out_free) begin
                        r_out.pos_x   <= r_nx;
                        r_out.pos_y   <= r_ny;
                        r_out.heading <= r_head;
                        r_xacc        <= r_nx;
                        r_yacc        <= r_ny;
                        r_angle       <= r_head;
                        r_out_valid   <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // an accepted transaction always starts the sequence
    `DDO_ASSERT(a_accept_starts, (i_valid && o_ready) |=> (r_state == ST_ML), "accept did not start sequence")
    // results appear only from the hand-over step
    `DDO_ASSERT(a_out_from_seq, $rose(r_out_valid) |-> ($past(r_state) == ST_OUT), "result from wrong step")
    // a stalled receiver holds the finished item in the last step
    `DDO_ASSERT(a_stall_holds, (r_state == ST_OUT && r_out_valid && !i_ready) |=> (r_state == ST_OUT), "result overwritten under stall")
    // no result pending right after reset
    `DDO_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

// ===== sim/differential_drive_odometry_top_tb.sv =====
// testbench for the odometry block: encoder count transactions checked against a pose predictor
`timescale 1ns / 100ps

module differential_drive_odometry_top_tb;
    import ddo_pkg::*;

    localparam int ROT_STEPS = CORDIC_STEPS_DEF;
    // settle for longer than one transaction in flight takes
    localparam int SETTLE_CYCLES = ROT_STEPS + 30;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_ITEMS = 250;
    localparam int REPORT_LIMIT = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_DIST_PER_COUNT;
    logic [31:0] i_cfg_data = '0;

    differential_drive_odometry_top #(
        .CORDIC_STEPS(ROT_STEPS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the block's registers and pose state
    bit [31:0] dist_per_count = DIST_PER_COUNT_RST;
    bit [31:0] inv_wheel_base = INV_WHEEL_BASE_RST;
    bit [31:0] prev_left = '0;
    bit [31:0] prev_right = '0;
    int        pose_x = 0;
    int        pose_y = 0;
    int        pose_h = 0;

    // arctangent of 2^-i in q2.30, truncated
    longint arctan_steps [0:30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2, 1
    };

    t_in  pending_counts [$];
    t_out predicted_poses [$];
    int   pose_errors = 0;
    int   poses_seen = 0;
    bit   idle_on = 1'b1;
    bit   long_hold_req = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_left = 0;
    int   gen_left = 0;
    int   gen_right = 0;
    t_out want;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // dead-reckoning update for one pair of encoder counts, all shifts are floors
    function automatic t_out advance_pose(input t_in cnt);
        bit [31:0] dl_raw, dr_raw;
        longint dl_cnt, dr_cnt, dl, dr, center, diff, dtheta, mid;
        longint cx, cy, cz, xs, ys, nx, ny, nh;
        longint dpc64, iwb64;
        bit flip;
        int i;
        t_out r;
        dpc64 = longint'({32'b0, dist_per_count});
        iwb64 = longint'({32'b0, inv_wheel_base});
        // wrapping count deltas read as signed
        dl_raw = cnt.count_left - prev_left;
        dr_raw = cnt.count_right - prev_right;
        dl_cnt = longint'($signed(dl_raw));
        dr_cnt = longint'($signed(dr_raw));
        prev_left = cnt.count_left;
        prev_right = cnt.count_right;

        dl = clamp32((dl_cnt * dpc64) >>> 8);
        dr = clamp32((dr_cnt * dpc64) >>> 8);
        center = (dl + dr) >>> 1;
        diff = clamp32(dl - dr);
        dtheta = clamp32((diff * iwb64) >>> 11);

        // midpoint heading folded into [-pi/2, pi/2], sign flip remembered
        flip = 1'b0;
        mid = longint'(pose_h) + (dtheta >>> 1);
        if (mid > PI_Q29) mid -= TWO_PI_Q29;
        else if (mid < -PI_Q29) mid += TWO_PI_Q29;
        if (mid > HALF_PI_Q29) begin
            mid -= PI_Q29;
            flip = 1'b1;
        end else if (mid < -HALF_PI_Q29) begin
            mid += PI_Q29;
            flip = 1'b1;
        end

        // rotation-mode cordic in q2.30
        cx = CORDIC_GAIN;
        cy = 0;
        cz = mid * 2;
        for (i = 0; i < ROT_STEPS && i < 31; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cz >= 0) begin
                cx -= ys;
                cy += xs;
                cz -= arctan_steps[i];
            end else begin
                cx += ys;
                cy -= xs;
                cz += arctan_steps[i];
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end

        nx = clamp32(longint'(pose_x) + ((center * cx) >>> 30));
        ny = clamp32(longint'(pose_y) + ((center * cy) >>> 30));
        nh = longint'(pose_h) + dtheta;
        if (nh > PI_Q29) nh -= TWO_PI_Q29;
        else if (nh < -PI_Q29) nh += TWO_PI_Q29;
        nh = clamp32(nh);

        pose_x = int'(nx);
        pose_y = int'(ny);
        pose_h = int'(nh);
        r.pos_x = pose_x;
        r.pos_y = pose_y;
        r.heading = pose_h;
        return r;
    endfunction

    // sender: offers queued counts, random idle bursts between transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predicted_poses.push_back(advance_pose(i_data));
            end
            // valid only drops after the transaction completes
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 13) - 1;
                    i_valid <= 1'b0;
                end else if (pending_counts.size() != 0) begin
                    i_data <= pending_counts.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each pose transaction, random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                poses_seen++;
                if (predicted_poses.size() == 0) begin
                    pose_errors++;
                    if (pose_errors <= REPORT_LIMIT)
                        $display("pose %0d with nothing expected: x %0d y %0d h %0d",
                                 poses_seen, o_data.pos_x, o_data.pos_y, o_data.heading);
                end else begin
                    want = predicted_poses.pop_front();
                    if (o_data.pos_x !== want.pos_x || o_data.pos_y !== want.pos_y ||
                        o_data.heading !== want.heading) begin
                        pose_errors++;
                        if (pose_errors <= REPORT_LIMIT)
                            $display("pose %0d mismatch: x exp %0d got %0d, y exp %0d got %0d, h exp %0d got %0d",
                                     poses_seen, want.pos_x, o_data.pos_x, want.pos_y,
                                     o_data.pos_y, want.heading, o_data.heading);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                i_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 13) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DIST_PER_COUNT) dist_per_count = val;
        else inv_wheel_base = val;
    endtask

    task automatic push_counts(input int l, input int r);
        t_in item;
        item.count_left = l;
        item.count_right = r;
        pending_counts.push_back(item);
        gen_left = l;
        gen_right = r;
    endtask

    // sampled at the falling edge so the sender's queue and valid are settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_counts.size() != 0 || i_valid || predicted_poses.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly plausible wheel motion, some wild jumps and counter extremes
    task automatic queue_motion(input int n);
        int dl, dr, l, r;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    dl = $urandom_range(0, 4000) - 2000;
                    dr = $urandom_range(0, 4000) - 2000;
                end
                4: begin
                    dl = $urandom_range(0, 4000) - 2000;
                    dr = dl;
                end
                5: begin
                    dl = $urandom_range(0, 8000) - 4000;
                    dr = -dl;
                end
                6: begin
                    dl = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                    dr = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                end
                7: begin
                    dl = $urandom;
                    dr = $urandom;
                end
                default: begin
                    dl = 0;
                    dr = 0;
                end
            endcase
            l = gen_left + dl;
            r = gen_right + dr;
            // absolute jumps: full random words or the counter extremes
            if (dl == 0 && dr == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    l = $urandom;
                    r = $urandom;
                end else begin
                    case ($urandom_range(0, 3))
                        0: l = 32'h7FFF_FFFF;
                        1: l = 32'h8000_0000;
                        2: l = 0;
                        default: l = -1;
                    endcase
                    case ($urandom_range(0, 3))
                        0: r = 32'h7FFF_FFFF;
                        1: r = 32'h8000_0000;
                        2: r = 0;
                        default: r = -1;
                    endcase
                end
            end
            push_counts(l, r);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: straight, turning, reverse, counter wrap, huge jumps
        push_counts(0, 0);
        push_counts(1000, 1000);
        push_counts(2500, 1000);
        push_counts(1000, 3000);
        push_counts(-4000, -4000);
        push_counts(32'h7FFF_FFF0, 32'h7FFF_FFF0);
        push_counts(32'h8000_0010, 32'h8000_0010);
        push_counts(32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();

        // largest registers: wheel distance, difference and turn saturate
        write_reg(CFG_DIST_PER_COUNT, 32'hFFFF_FFFF);
        write_reg(CFG_INV_WHEEL_BASE, 32'hFFFF_FFFF);
        push_counts(0, 0);
        push_counts(1, 0);
        push_counts(0, 1);
        push_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_counts(0, 0);
        push_counts(32'h8000_0000, 32'h7FFF_FFFF);
        // repeated long straight runs drive the position into saturation
        push_counts(32'hC000_0000, 32'hC000_0000);
        push_counts(0, 0);
        push_counts(32'h4000_0000, 32'h4000_0000);
        wait_idle();

        // zero registers: no distance, no turn
        write_reg(CFG_DIST_PER_COUNT, 32'h0);
        write_reg(CFG_INV_WHEEL_BASE, 32'h0);
        push_counts(5, 7);
        push_counts(32'h1234_5678, -3);
        push_counts(-1, 32'h8000_0000);
        wait_idle();

        // smallest nonzero registers
        write_reg(CFG_DIST_PER_COUNT, 32'h1);
        write_reg(CFG_INV_WHEEL_BASE, 32'h1);
        push_counts(-1000, 2000);
        push_counts(32'h7FFF_FFFF, -1);
        push_counts(0, 32'h7FFF_FFFF);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin
                    write_reg(CFG_DIST_PER_COUNT, DIST_PER_COUNT_RST);
                    write_reg(CFG_INV_WHEEL_BASE, INV_WHEEL_BASE_RST);
                end
                1: begin
                    write_reg(CFG_DIST_PER_COUNT, $urandom_range(32'h0001_0000, 32'h0010_0000));
                    write_reg(CFG_INV_WHEEL_BASE, $urandom_range(32'h0004_0000, 32'h0040_0000));
                end
                2: begin
                    write_reg(CFG_DIST_PER_COUNT, $urandom);
                    write_reg(CFG_INV_WHEEL_BASE, $urandom);
                end
                default: begin
                    write_reg(CFG_DIST_PER_COUNT, 32'hFFFF_FFFF);
                    write_reg(CFG_INV_WHEEL_BASE, 32'h1);
                end
            endcase
            // the final stretch runs without any idling
            if (p == 7) idle_on = 1'b0;
            @(negedge i_clk);
            if (p == 5) begin
                // sender stops halfway until every pose is back
                queue_motion(PHASE_ITEMS / 2);
                wait_idle();
                queue_motion(PHASE_ITEMS / 2);
            end else begin
                queue_motion(PHASE_ITEMS);
                // receiver goes quiet while the sender keeps offering
                if (p == 3) long_hold_req = 1'b1;
            end
            wait_idle();
        end

        if (pose_errors == 0 && predicted_poses.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // timeout far beyond the slowest expected run, reported as a failure
    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ddo_pkg.sv
rtl/differential_drive_odometry_top.sv
sim/differential_drive_odometry_top_tb.sv
